// ===== src/shl_pkg.sv =====
// Shared types and codes for the sorted hit list merger.
// Used by the channel interfaces, controller, datapath and checker.
package shl_pkg;

    localparam int unsigned LIST_DEPTH_DEF = 1024;

    localparam int unsigned ACT_W   = 2;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned RIDX_W  = 10;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

    // Field order gives the sort key: an unsigned compare of the whole word
    // orders by strand, read id, read offset, self offset.
    typedef struct packed {
        logic              strand;
        logic [WORD_W-1:0] rd;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] qry_end;
    } t_entry;

    typedef struct packed {
        logic start;        // latch key, reset result fields
        logic clear_counts;
        logic batch_bump;
        logic set_full;
        logic set_beyond;
        logic rd_ridx;      // read at the incoming index
        logic idx_init;     // point at the last entry and read it
        logic step;         // move down one entry and read it
        logic shift_wr;     // move the entry just read up one place
        logic key_wr_hi;    // new hit goes above the entry just read
        logic key_wr_zero;  // new hit goes to the bottom
        logic commit_ins;
        logic cap_entry;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] in_action;
        logic             in_last;
        logic             full;
        logic             empty;
        logic             beyond;
        logic             entry_ge;
        logic             idx_zero;
        logic             out_free;
    } t_stat;

endpackage

// ===== src/shl_ifs.sv =====
// Valid/ready channel interfaces for hits in and results out.
// Depends on shl_pkg.
interface shl_in_if;
    logic                            valid;
    logic                            ready;
    logic [shl_pkg::ACT_W-1:0]       action;
    logic [shl_pkg::WORD_W-1:0]      hit_read;
    logic [shl_pkg::WORD_W-1:0]      hit_offset;
    logic [shl_pkg::WORD_W-1:0]      hit_self_offset;
    logic                            hit_strand;
    logic                            batch_last;
    logic [shl_pkg::RIDX_W-1:0]      read_index;

    modport source (
        output valid, action, hit_read, hit_offset, hit_self_offset, hit_strand,
               batch_last, read_index,
        input  ready
    );
    modport sink (
        input  valid, action, hit_read, hit_offset, hit_self_offset, hit_strand,
               batch_last, read_index,
        output ready
    );
endinterface

interface shl_out_if;
    logic                            valid;
    logic                            ready;
    logic [shl_pkg::STAT_W-1:0]      status;
    logic [shl_pkg::WORD_W-1:0]      out_read;
    logic [shl_pkg::WORD_W-1:0]      out_offset;
    logic [shl_pkg::WORD_W-1:0]      out_self_offset;
    logic                            out_strand;
    logic [shl_pkg::CNT_W-1:0]       entry_count;
    logic [shl_pkg::CNT_W-1:0]       forward_count;
    logic [shl_pkg::WORD_W-1:0]      batches_merged;

    modport source (
        output valid, status, out_read, out_offset, out_self_offset, out_strand,
               entry_count, forward_count, batches_merged,
        input  ready
    );
    modport sink (
        input  valid, status, out_read, out_offset, out_self_offset, out_strand,
               entry_count, forward_count, batches_merged,
        output ready
    );
endinterface

// ===== src/shl_ctrl.sv =====
// Controller for the sorted hit list merger: sequences clear, insert scan
// and indexed read. Depends on shl_pkg.
module shl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  shl_pkg::t_stat i_stat,
    output shl_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PLACE  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RESP;
                    unique case (i_stat.in_action)
                        shl_pkg::ACT_CLEAR: begin
                            o_cmd.clear_counts = 1'b1;
                        end
                        shl_pkg::ACT_INSERT: begin
                            o_cmd.batch_bump = i_stat.in_last;
                            if (i_stat.full) begin
                                o_cmd.set_full = 1'b1;
                            end else if (i_stat.empty) begin
                                n_state = S_PLACE;
                            end else begin
                                o_cmd.idx_init = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                        shl_pkg::ACT_READ: begin
                            if (i_stat.beyond) begin
                                o_cmd.set_beyond = 1'b1;
                            end else begin
                                o_cmd.rd_ridx = 1'b1;
                                n_state       = S_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                o_cmd.cap_entry = 1'b1;
                n_state         = S_RESP;
            end
            S_SCAN: begin
                // stored entries at or above the new key move up; equal keys too
                if (i_stat.entry_ge) begin
                    o_cmd.shift_wr = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.key_wr_hi  = 1'b1;
                    o_cmd.commit_ins = 1'b1;
                    n_state          = S_RESP;
                end
            end
            S_PLACE: begin
                o_cmd.key_wr_zero = 1'b1;
                o_cmd.commit_ins  = 1'b1;
                n_state           = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/shl_dpath.sv =====
// Datapath for the sorted hit list merger: entry memory, scan index,
// counters, result and output registers. Depends on shl_pkg.
module shl_dpath #(
    parameter int unsigned LIST_DEPTH = shl_pkg::LIST_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  shl_pkg::t_cmd                 i_cmd,
    output shl_pkg::t_stat                o_stat,
    // incoming item
    input  logic [shl_pkg::ACT_W-1:0]     i_action,
    input  logic [shl_pkg::WORD_W-1:0]    i_hit_read,
    input  logic [shl_pkg::WORD_W-1:0]    i_hit_offset,
    input  logic [shl_pkg::WORD_W-1:0]    i_hit_self_offset,
    input  logic                          i_hit_strand,
    input  logic                          i_batch_last,
    input  logic [shl_pkg::RIDX_W-1:0]    i_read_index,
    // result register
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [shl_pkg::STAT_W-1:0]    o_status,
    output shl_pkg::t_entry               o_entry,
    output logic [shl_pkg::CNT_W-1:0]     o_entry_count,
    output logic [shl_pkg::CNT_W-1:0]     o_forward_count,
    output logic [shl_pkg::WORD_W-1:0]    o_batches_merged
);

    localparam int unsigned AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
    localparam int unsigned CMPW = CW + shl_pkg::RIDX_W;
    localparam int unsigned EXTW = CW + shl_pkg::CNT_W;

    shl_pkg::t_entry r_mem [LIST_DEPTH];
    shl_pkg::t_entry r_rdata;
    shl_pkg::t_entry r_key;
    shl_pkg::t_entry wr_data;
    shl_pkg::t_entry r_res_entry;

    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  last_idx;
    logic           rd_en;
    logic           wr_en;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_fwd;
    logic [shl_pkg::WORD_W-1:0] r_batch;
    logic [shl_pkg::STAT_W-1:0] r_res_status;

    logic [EXTW-1:0] count_ext;
    logic [EXTW-1:0] fwd_ext;

    assign last_idx = AW'(r_count - CW'(1));

    // status to the controller
    assign o_stat.in_action = i_action;
    assign o_stat.in_last   = i_batch_last;
    assign o_stat.full      = (r_count == CW'(LIST_DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.beyond    = (CMPW'(i_read_index) >= CMPW'(r_count));
    assign o_stat.entry_ge  = (r_rdata >= r_key);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    // memory address and data selection
    always_comb begin
        rd_en   = i_cmd.rd_ridx || i_cmd.idx_init || i_cmd.step;
        rd_addr = r_idx - AW'(1);
        if (i_cmd.rd_ridx) begin
            rd_addr = AW'(i_read_index);
        end else if (i_cmd.idx_init) begin
            rd_addr = last_idx;
        end
        wr_en   = i_cmd.shift_wr || i_cmd.key_wr_hi || i_cmd.key_wr_zero;
        wr_addr = i_cmd.key_wr_zero ? '0 : (r_idx + AW'(1));
        wr_data = i_cmd.shift_wr ? r_rdata : r_key;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // key, scan index and per-item result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key.strand  <= i_hit_strand;
            r_key.rd      <= i_hit_read;
            r_key.offset  <= i_hit_offset;
            r_key.qry_end <= i_hit_self_offset;
            r_res_status  <= shl_pkg::ST_OK;
            r_res_entry   <= '0;
        end
        if (i_cmd.set_full) begin
            r_res_status <= shl_pkg::ST_FULL;
        end
        if (i_cmd.set_beyond) begin
            r_res_status <= shl_pkg::ST_BEYOND;
        end
        if (i_cmd.cap_entry) begin
            r_res_entry <= r_rdata;
        end
        if (i_cmd.idx_init) begin
            r_idx <= last_idx;
        end else if (i_cmd.step) begin
            r_idx <= r_idx - AW'(1);
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fwd   <= '0;
            r_batch <= '0;
        end else begin
            if (i_cmd.clear_counts) begin
                r_count <= '0;
                r_fwd   <= '0;
                r_batch <= '0;
            end
            if (i_cmd.commit_ins) begin
                r_count <= r_count + CW'(1);
                if (!r_key.strand) begin
                    r_fwd <= r_fwd + CW'(1);
                end
            end
            if (i_cmd.batch_bump) begin
                r_batch <= r_batch + shl_pkg::WORD_W'(1);
            end
        end
    end

    assign count_ext = EXTW'(r_count);
    assign fwd_ext   = EXTW'(r_fwd);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status         <= r_res_status;
            o_entry          <= r_res_entry;
            o_entry_count    <= count_ext[shl_pkg::CNT_W-1:0];
            o_forward_count  <= fwd_ext[shl_pkg::CNT_W-1:0];
            o_batches_merged <= r_batch;
        end
    end

endmodule

// ===== src/sorted_hit_list_merger.sv =====
// Sorted hit list merger top level: channel wiring of controller and datapath.
// Depends on shl_pkg, shl_ifs, shl_ctrl and shl_dpath.
//
// Keeps up to LIST_DEPTH hits in one memory, sorted by strand, read id, read
// offset and self offset; a new hit lands below any stored hit with an equal
// key. One item is handled at a time and each yields one result. An insert
// scans down from the top of the list, one stored entry per cycle through the
// memory's read port, moving each entry at or above the new key up one place.
// The result sits in an output register; the next item waits while that
// register is still full at the end of its work. The memory has no reset and
// needs no clearing pass.
module sorted_hit_list_merger #(
    parameter int unsigned LIST_DEPTH = shl_pkg::LIST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    shl_in_if.sink    i_hit,
    shl_out_if.source o_res
);

    shl_pkg::t_cmd   cmd;
    shl_pkg::t_stat  stat;
    shl_pkg::t_entry res_entry;

    shl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hit.valid),
        .o_in_ready (i_hit.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    shl_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_action          (i_hit.action),
        .i_hit_read        (i_hit.hit_read),
        .i_hit_offset      (i_hit.hit_offset),
        .i_hit_self_offset (i_hit.hit_self_offset),
        .i_hit_strand      (i_hit.hit_strand),
        .i_batch_last      (i_hit.batch_last),
        .i_read_index      (i_hit.read_index),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_status          (o_res.status),
        .o_entry           (res_entry),
        .o_entry_count     (o_res.entry_count),
        .o_forward_count   (o_res.forward_count),
        .o_batches_merged  (o_res.batches_merged)
    );

    assign o_res.out_read        = res_entry.rd;
    assign o_res.out_offset      = res_entry.offset;
    assign o_res.out_self_offset = res_entry.qry_end;
    assign o_res.out_strand      = res_entry.strand;

endmodule

// ===== src/shl_checker.sv =====
// Port-level checks for the sorted hit list merger, bound to the top level.
// Depends on shl_pkg and sorted_hit_list_merger.
module shl_checker #(
    parameter int unsigned LIST_DEPTH = shl_pkg::LIST_DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [shl_pkg::STAT_W-1:0]    i_status,
    input logic [shl_pkg::WORD_W-1:0]    i_out_read,
    input logic [shl_pkg::WORD_W-1:0]    i_out_offset,
    input logic [shl_pkg::WORD_W-1:0]    i_out_self_offset,
    input logic                          i_out_strand,
    input logic [shl_pkg::CNT_W-1:0]     i_entry_count,
    input logic [shl_pkg::CNT_W-1:0]     i_forward_count
);

    localparam logic [shl_pkg::CNT_W-1:0] FULL_CNT = shl_pkg::CNT_W'(LIST_DEPTH);

    // one item at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_entry_count)
            && $stable(i_out_read))
        else $error("stalled result changed");

    a_fwd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_forward_count <= i_entry_count)
        else $error("forward count above entry count");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == shl_pkg::ST_FULL) |-> i_entry_count == FULL_CNT)
        else $error("insert dropped while list not full");

    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == shl_pkg::ST_FULL || i_status == shl_pkg::ST_BEYOND)
        |-> i_out_read == '0 && i_out_offset == '0 && i_out_self_offset == '0
            && !i_out_strand)
        else $error("entry fields set on a failed item");

endmodule

bind sorted_hit_list_merger shl_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_shl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_hit.valid),
    .i_in_ready        (i_hit.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_status          (o_res.status),
    .i_out_read        (o_res.out_read),
    .i_out_offset      (o_res.out_offset),
    .i_out_self_offset (o_res.out_self_offset),
    .i_out_strand      (o_res.out_strand),
    .i_entry_count     (o_res.entry_count),
    .i_forward_count   (o_res.forward_count)
);
